/* design/particle_wall_specular_collision_assert.svh */
// Assertion macros used by the divider
`ifndef PARTICLE_WALL_SPECULAR_COLLISION_ASSERT_SVH
`define PARTICLE_WALL_SPECULAR_COLLISION_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define PWSC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pwsc assertion failed");

// Next-cycle implication, disabled in reset
`define PWSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pwsc assertion failed");

`endif

/* design/pwsc_pkg.sv */
package pwsc_pkg;

   localparam int IDX_W     = 16;
   localparam int DATA_W    = 32;
   localparam int TIME_W    = 31;
   localparam int COMP_W    = 21;
   localparam int PVEC_W    = 63;
   localparam int HALF_W    = 64;
   localparam int FRAC_W    = 16;
   localparam int WIDEN_SH  = 5;
   localparam int UNIT_FR   = 19;
   localparam int REL_W     = 33;
   localparam int PROD_W    = 54;
   localparam int SUM_W     = 56;
   localparam int SN_W      = 58;
   localparam int DIV_W     = 55;
   localparam int DIV_STEPS = 31;
   localparam int DFULL_W   = 49;
   localparam int DIST_W    = 42;
   localparam int FAR_SH    = 40;
   localparam int PLANE_W   = 63;
   localparam int WIDE_W    = 64;
   localparam int REG_IDX_W = 3;
   localparam int TDATA_W   = 240;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_NORMAL   = 3'd0,
      REG_AXIS_U   = 3'd1,
      REG_AXIS_V   = 3'd2,
      REG_CENTER   = 3'd3,
      REG_WALL_VEL = 3'd4,
      REG_HALF     = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [PVEC_W-1:0] normal;
      logic [PVEC_W-1:0] axis_u;
      logic [PVEC_W-1:0] axis_v;
      logic [PVEC_W-1:0] center;
      logic [PVEC_W-1:0] wall_vel;
      logic [HALF_W-1:0] half;
   } cfg_type;

   // Particle record that travels down the pipeline
   typedef struct packed {
      logic [IDX_W-1:0]           idx;
      logic [2:0][DATA_W-1:0]     pos;
      logic [2:0][DATA_W-1:0]     vel;
      logic [2:0][DATA_W-1:0]     vnew;
      logic [2:0][REL_W-1:0]      cp;
      logic [2:0][REL_W-1:0]      vr;
      logic [TIME_W-1:0]          tl;
      logic                       hit;
   } item_type;

   // Pick one 21-bit component out of a packed vector
   function automatic logic signed [COMP_W-1:0] comp(input logic [PVEC_W-1:0] v,
                                                     input logic [1:0] i);
      comp = $signed(v[COMP_W*i +: COMP_W]);
   endfunction

   // Clamp to the signed 32-bit range
   function automatic logic [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(64'sh7FFF_FFFF);
      lo = -hi - WIDE_W'(64'sd1);
      if (x > hi) begin
         sat32 = DATA_W'(hi);
      end else if (x < lo) begin
         sat32 = DATA_W'(lo);
      end else begin
         sat32 = DATA_W'(x);
      end
   endfunction

endpackage

/* design/pwsc_cfg.sv */
module pwsc_cfg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pwsc_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [pwsc_pkg::HALF_W-1:0]       csr_wdata,
   output pwsc_pkg::cfg_type                 cfg
);
   import pwsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_idx_type'(csr_index))
            REG_NORMAL:   cfg_in.normal   = csr_wdata[PVEC_W-1:0];
            REG_AXIS_U:   cfg_in.axis_u   = csr_wdata[PVEC_W-1:0];
            REG_AXIS_V:   cfg_in.axis_v   = csr_wdata[PVEC_W-1:0];
            REG_CENTER:   cfg_in.center   = csr_wdata[PVEC_W-1:0];
            REG_WALL_VEL: cfg_in.wall_vel = csr_wdata[PVEC_W-1:0];
            REG_HALF:     cfg_in.half     = csr_wdata;
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/pwsc_front.sv */
module pwsc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  pwsc_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   input  pwsc_pkg::item_type            in_item,
   output logic                          out_valid,
   output pwsc_pkg::item_type            out_item,
   output logic [pwsc_pkg::DIV_W-1:0]    out_num,
   output logic [pwsc_pkg::DIV_W-1:0]    out_dn
);
   import pwsc_pkg::*;

   logic [4:0] v_ff;
   item_type   item1_ff, item2_ff, item3_ff, item4_ff, item5_ff;
   item_type   item1_in, item3_in, item5_in;

   logic signed [PROD_W-1:0] nvr_ff [3];
   logic signed [PROD_W-1:0] ncp_ff [3];
   logic signed [PROD_W-1:0] nvr_in [3];
   logic signed [PROD_W-1:0] ncp_in [3];
   logic signed [SUM_W-1:0]  den_ff, num_ff, den_in, num_in;
   logic signed [SN_W-1:0]   sn_ff [3];
   logic signed [SN_W-1:0]   sn_in [3];
   logic [DIV_W-1:0]         dn4_ff, num4_ff, dn5_ff, num5_ff;
   logic signed [SUM_W-UNIT_FR-1:0] speed;

   // Stage 1: velocity relative to the wall and offset from the center
   always_comb begin
      item1_in = in_item;
      for (int i = 0; i < 3; i++) begin
         item1_in.vr[i] = REL_W'($signed(in_item.vel[i]))
                        - (REL_W'(comp(cfg.wall_vel, 2'(i))) <<< WIDEN_SH);
         item1_in.cp[i] = REL_W'($signed(in_item.pos[i]))
                        - (REL_W'(comp(cfg.center, 2'(i))) <<< WIDEN_SH);
      end
   end

   // Stage 2: normal products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nvr_in[i] = comp(cfg.normal, 2'(i)) * $signed(item1_ff.vr[i]);
         ncp_in[i] = comp(cfg.normal, 2'(i)) * $signed(item1_ff.cp[i]);
      end
   end

   // Stage 3: sum the dot products and test approach
   always_comb begin
      den_in = SUM_W'(nvr_ff[0]) + SUM_W'(nvr_ff[1]) + SUM_W'(nvr_ff[2]);
      num_in = SUM_W'(ncp_ff[0]) + SUM_W'(ncp_ff[1]) + SUM_W'(ncp_ff[2]);
      item3_in = item2_ff;
      item3_in.hit = item2_ff.hit & den_in[SUM_W-1] & ~num_in[SUM_W-1];
   end

   // Stage 4: normal speed times normal
   assign speed = $signed(den_ff[SUM_W-1:UNIT_FR]);
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sn_in[i] = speed * comp(cfg.normal, 2'(i));
      end
   end

   // Stage 5: mirrored velocity, saturated
   always_comb begin
      item5_in = item4_ff;
      for (int i = 0; i < 3; i++) begin
         item5_in.vnew[i] = sat32(WIDE_W'($signed(item4_ff.vel[i]))
                                  - WIDE_W'(sn_ff[i] >>> (UNIT_FR - 1)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item1_ff <= item1_in;
         item2_ff <= item1_ff;
         nvr_ff   <= nvr_in;
         ncp_ff   <= ncp_in;
         item3_ff <= item3_in;
         den_ff   <= den_in;
         num_ff   <= num_in;
         item4_ff <= item3_ff;
         sn_ff    <= sn_in;
         dn4_ff   <= DIV_W'(-den_ff);
         num4_ff  <= DIV_W'(num_ff);
         item5_ff <= item5_in;
         dn5_ff   <= dn4_ff;
         num5_ff  <= num4_ff;
      end
   end

   assign out_valid = v_ff[4];
   assign out_item  = item5_ff;
   assign out_num   = num5_ff;
   assign out_dn    = dn5_ff;

endmodule

/* design/pwsc_div.sv */
`include "particle_wall_specular_collision_assert.svh"
module pwsc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  pwsc_pkg::item_type            in_item,
   input  logic [pwsc_pkg::DIV_W-1:0]    in_num,
   input  logic [pwsc_pkg::DIV_W-1:0]    in_dn,
   output logic                          out_valid,
   output pwsc_pkg::item_type            out_item,
   output logic [pwsc_pkg::TIME_W-1:0]   out_t
);
   import pwsc_pkg::*;

   localparam int LAST = DIV_STEPS - 1;

   logic                 v_ff   [DIV_STEPS];
   item_type             item_ff[DIV_STEPS];
   logic [DIV_W-1:0]     rem_ff [DIV_STEPS];
   logic [TIME_W-1:0]    quo_ff [DIV_STEPS];
   logic [DIV_W-1:0]     num_ff [DIV_STEPS];
   logic [DIV_W-1:0]     dn_ff  [DIV_STEPS];
   logic [DIV_W-1:0]     rem_init;
   logic                 ovf;

   // Quotient of 2^31 or more is out of range
   assign rem_init = in_num >> (DIV_STEPS - FRAC_W);
   assign ovf      = rem_init >= in_dn;

   // One quotient bit per stage, restoring division
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int B = DIV_STEPS - 1 - k;
      logic             v_src;
      item_type         item_src;
      logic [DIV_W-1:0] rem_src, num_src, dn_src;
      logic [TIME_W-1:0] quo_src;
      logic             x_bit;
      logic [DIV_W:0]   trial;
      logic             ge;

      if (k == 0) begin : g_first
         always_comb begin
            v_src        = in_valid;
            item_src     = in_item;
            item_src.hit = in_item.hit & ~ovf;
            rem_src      = rem_init;
            quo_src      = '0;
            num_src      = in_num;
            dn_src       = in_dn;
         end
      end else begin : g_next
         always_comb begin
            v_src    = v_ff[k-1];
            item_src = item_ff[k-1];
            rem_src  = rem_ff[k-1];
            quo_src  = quo_ff[k-1];
            num_src  = num_ff[k-1];
            dn_src   = dn_ff[k-1];
         end
      end

      if (B >= FRAC_W) begin : g_dbit
         assign x_bit = num_src[B-FRAC_W];
      end else begin : g_zbit
         assign x_bit = 1'b0;
      end

      assign trial = {rem_src, x_bit};
      assign ge    = trial >= {1'b0, dn_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            item_ff[k] <= item_src;
            rem_ff[k]  <= ge ? DIV_W'(trial - {1'b0, dn_src}) : DIV_W'(trial);
            quo_ff[k]  <= {quo_src[TIME_W-2:0], ge};
            num_ff[k]  <= num_src;
            dn_ff[k]   <= dn_src;
         end
      end
   end

   assign out_valid = v_ff[LAST];
   assign out_item  = item_ff[LAST];
   assign out_t     = quo_ff[LAST];

   `PWSC_ASSERT_IMPL(a_rem_below_div, clock, reset, v_ff[LAST] && item_ff[LAST].hit, rem_ff[LAST] < dn_ff[LAST])
   `PWSC_ASSERT_NEXT(a_ovf_is_miss, clock, reset, adv && in_valid && ovf, !item_ff[0].hit)
   `PWSC_ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable(quo_ff[LAST]) && $stable(v_ff[LAST]))

endmodule

/* design/pwsc_back.sv */
module pwsc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  pwsc_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   input  pwsc_pkg::item_type            in_item,
   input  logic [pwsc_pkg::TIME_W-1:0]   in_t,
   output logic                          out_valid,
   output pwsc_pkg::item_type            out_item
);
   import pwsc_pkg::*;

   localparam logic signed [DFULL_W-1:0] FAR_LIM = DFULL_W'(1) <<< FAR_SH;

   logic [3:0] v_ff;
   item_type   item1_ff, item2_ff, item3_ff, out_ff;
   item_type   item1_in, item2_in, out_in;
   logic [TIME_W-1:0] tln1_ff, tln2_ff, tln3_ff;

   logic signed [WIDE_W-1:0]  pv_ff [3];
   logic signed [WIDE_W-1:0]  pe_ff [3];
   logic signed [WIDE_W-1:0]  pv_in [3];
   logic signed [WIDE_W-1:0]  pe_in [3];
   logic signed [DFULL_W-1:0] d_full [3];
   logic [DIST_W-1:0]         d_ff [3];
   logic [DIST_W-1:0]         d_in [3];
   logic [2:0][DATA_W-1:0]    newp_ff, newp3_ff, newp_in;
   logic signed [PLANE_W-1:0] du_ff [3];
   logic signed [PLANE_W-1:0] dv_ff [3];
   logic signed [PLANE_W-1:0] du_in [3];
   logic signed [PLANE_W-1:0] dv_in [3];
   logic signed [WIDE_W-1:0]  u_sum, v_sum;
   logic [WIDE_W-1:0]         u_abs, v_abs, hu, hv;
   logic                      in_bounds;

   // Stage 1: travel products and remaining-time check
   always_comb begin
      item1_in     = in_item;
      item1_in.hit = in_item.hit & (in_t <= in_item.tl);
      for (int i = 0; i < 3; i++) begin
         pv_in[i] = $signed(in_item.vr[i]) * $signed({1'b0, in_t});
         pe_in[i] = $signed(in_item.vel[i]) * $signed({1'b0, in_t});
      end
   end

   // Stage 2: crossing offset, far test and new position
   always_comb begin
      item2_in = item1_ff;
      for (int i = 0; i < 3; i++) begin
         d_full[i]  = DFULL_W'($signed(item1_ff.cp[i])) + DFULL_W'(pv_ff[i] >>> FRAC_W);
         d_in[i]    = d_full[i][DIST_W-1:0];
         newp_in[i] = sat32(WIDE_W'($signed(item1_ff.pos[i])) + (pe_ff[i] >>> FRAC_W));
         if (d_full[i] > FAR_LIM || d_full[i] < -FAR_LIM) begin
            item2_in.hit = 1'b0;
         end
      end
   end

   // Stage 3: in-plane products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         du_in[i] = $signed(d_ff[i]) * comp(cfg.axis_u, 2'(i));
         dv_in[i] = $signed(d_ff[i]) * comp(cfg.axis_v, 2'(i));
      end
   end

   // Stage 4: bound test and result select
   always_comb begin
      u_sum = WIDE_W'(du_ff[0]) + WIDE_W'(du_ff[1]) + WIDE_W'(du_ff[2]);
      v_sum = WIDE_W'(dv_ff[0]) + WIDE_W'(dv_ff[1]) + WIDE_W'(dv_ff[2]);
      u_abs = u_sum[WIDE_W-1] ? WIDE_W'(-u_sum) : WIDE_W'(u_sum);
      v_abs = v_sum[WIDE_W-1] ? WIDE_W'(-v_sum) : WIDE_W'(v_sum);
      hu    = WIDE_W'(cfg.half[DATA_W-1:0]) << UNIT_FR;
      hv    = WIDE_W'(cfg.half[HALF_W-1:DATA_W]) << UNIT_FR;
      in_bounds = (u_abs <= hu) && (v_abs <= hv);
      out_in     = item3_ff;
      out_in.hit = item3_ff.hit & in_bounds;
      if (out_in.hit) begin
         out_in.pos = newp3_ff;
         out_in.vel = item3_ff.vnew;
         out_in.tl  = tln3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item1_ff <= item1_in;
         pv_ff    <= pv_in;
         pe_ff    <= pe_in;
         tln1_ff  <= in_item.tl - in_t;
         item2_ff <= item2_in;
         d_ff     <= d_in;
         newp_ff  <= newp_in;
         tln2_ff  <= tln1_ff;
         item3_ff <= item2_ff;
         du_ff    <= du_in;
         dv_ff    <= dv_in;
         newp3_ff <= newp_ff;
         tln3_ff  <= tln2_ff;
         out_ff   <= out_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_item  = out_ff;

endmodule

/* design/particle_wall_specular_collision.sv */
// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   tdata particle, tuser alive
// rsp_      out        rsp_tvalid/rsp_tready   tdata particle, tuser hit
// csr_      in         csr_valid/csr_ready     csr_index, csr_wdata
//
// One particle enters per cycle while the pipeline advances.
// The pipeline is the restoring divider for the hit time, one quotient bit
// per stage over 31 stages, plus 5 front and 4 back stages.
// Synchronous active-high reset clears valid bits and the wall registers.
// The whole pipeline holds while the output register is full and not taken.
module particle_wall_specular_collision (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // idx[15:0], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_left[238:208], 0
   input  logic [pwsc_pkg::TDATA_W-1:0]      req_tdata,
   // alive
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_index, out_pos_x/y/z, out_vel_x/y/z, out_time_left[238:208], 0
   output logic [pwsc_pkg::TDATA_W-1:0]      rsp_tdata,
   // hit
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pwsc_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [pwsc_pkg::HALF_W-1:0]       csr_wdata
);
   import pwsc_pkg::*;

   cfg_type          cfg;
   item_type         in_item, f_item, d_item, o_item;
   logic             adv, f_valid, d_valid;
   logic [DIV_W-1:0] f_num, f_dn;
   logic [TIME_W-1:0] d_t;

   // Advance while the output register is free or being taken
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Unpack the request transaction
   always_comb begin
      in_item     = '0;
      in_item.idx = req_tdata[IDX_W-1:0];
      for (int i = 0; i < 3; i++) begin
         in_item.pos[i] = req_tdata[IDX_W + DATA_W*i +: DATA_W];
         in_item.vel[i] = req_tdata[IDX_W + DATA_W*(3+i) +: DATA_W];
      end
      in_item.tl  = req_tdata[IDX_W + DATA_W*6 +: TIME_W];
      in_item.hit = req_tuser;
   end

   pwsc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pwsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_item   (in_item),
      .out_valid (f_valid),
      .out_item  (f_item),
      .out_num   (f_num),
      .out_dn    (f_dn)
   );

   pwsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_item   (f_item),
      .in_num    (f_num),
      .in_dn     (f_dn),
      .out_valid (d_valid),
      .out_item  (d_item),
      .out_t     (d_t)
   );

   pwsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg),
      .in_valid  (d_valid),
      .in_item   (d_item),
      .in_t      (d_t),
      .out_valid (rsp_tvalid),
      .out_item  (o_item)
   );

   // Pack the response transaction
   always_comb begin
      rsp_tdata              = '0;
      rsp_tdata[IDX_W-1:0]   = o_item.idx;
      for (int i = 0; i < 3; i++) begin
         rsp_tdata[IDX_W + DATA_W*i +: DATA_W]     = o_item.pos[i];
         rsp_tdata[IDX_W + DATA_W*(3+i) +: DATA_W] = o_item.vel[i];
      end
      rsp_tdata[IDX_W + DATA_W*6 +: TIME_W] = o_item.tl;
   end
   assign rsp_tuser = o_item.hit;

endmodule

/* tb/testbench.sv */
module testbench;
   import pwsc_pkg::*;

   localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int    IDLE_LIMIT = 4000;
   localparam int    DRAIN_WAIT = 60;
   localparam longint ONE_Q16 = 64'sd65536;
   localparam longint ONE_UNIT = 64'sd524288;
   localparam longint DIAG_UNIT = 64'sd370728;
   localparam int    SPAN_MAX = 1 << 24;

   // Particle record in tdata order, index in the lowest bits
   typedef struct packed {
      logic [TIME_W-1:0]      tl;
      logic [2:0][DATA_W-1:0] vel;
      logic [2:0][DATA_W-1:0] pos;
      logic [IDX_W-1:0]       idx;
   } particle_t;

   typedef struct {
      particle_t p;
      bit        flag;
   } bounce_t;

   typedef struct {
      particle_t p;
      bit        alive;
      bit        passes;
   } stim_row_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [REG_IDX_W-1:0]  csr_index;
   logic [HALF_W-1:0]     csr_wdata;

   // Shadow copy of the wall registers
   logic [PVEC_W-1:0] wall_normal, wall_axis_u, wall_axis_v, wall_center, wall_vel;
   logic [HALF_W-1:0] wall_half;

   bounce_t bounce_q[$];
   int  errors;
   int  sent_count;
   int  hit_count;
   int  csr_count;
   int  idle_cycles;
   bit  idling_on;
   int  stall_left;

   particle_wall_specular_collision dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Component i of a packed vector, scaled up by sh bits
   function automatic longint vec_comp(input logic [PVEC_W-1:0] v, input int i,
                                       input int sh);
      logic signed [COMP_W-1:0] raw;
      raw = v[COMP_W*i +: COMP_W];
      return longint'(raw) <<< sh;
   endfunction

   function automatic logic [HALF_W-1:0] pack_vec(input longint x, input longint y,
                                                  input longint z);
      logic [COMP_W-1:0] a, b, c;
      a = x[COMP_W-1:0];
      b = y[COMP_W-1:0];
      c = z[COMP_W-1:0];
      return {1'b0, c, b, a};
   endfunction

   function automatic logic [DATA_W-1:0] clamp32(input longint x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[DATA_W-1:0];
   endfunction

   // Expected particle after the wall test; struck says whether it bounced
   function automatic particle_t bounce_particle(input particle_t p, input bit alive,
                                                 output bit struck);
      longint pv[3], vv[3], nv[3], uv[3], wv[3], cv[3], mv[3], vr[3], dv[3];
      longint den, num, dn, q, r, f, t, u, v, hu, hv, s;
      particle_t o;
      int i;
      o = p;
      struck = 1'b0;
      t = 0;
      q = 0;
      for (i = 0; i < 3; i++) begin
         pv[i] = longint'($signed(p.pos[i]));
         vv[i] = longint'($signed(p.vel[i]));
         nv[i] = vec_comp(wall_normal, i, 0);
         uv[i] = vec_comp(wall_axis_u, i, 0);
         wv[i] = vec_comp(wall_axis_v, i, 0);
         cv[i] = vec_comp(wall_center, i, WIDEN_SH);
         mv[i] = vec_comp(wall_vel, i, WIDEN_SH);
      end
      if (!alive) return o;
      for (i = 0; i < 3; i++) vr[i] = vv[i] - mv[i];
      den = nv[0]*vr[0] + nv[1]*vr[1] + nv[2]*vr[2];
      num = nv[0]*(pv[0]-cv[0]) + nv[1]*(pv[1]-cv[1]) + nv[2]*(pv[2]-cv[2]);
      dn = -den;
      struck = (den < 0) && (num >= 0);
      if (struck) begin
         q = num / dn;
         if (q >= 64'sd32768) struck = 1'b0;
      end
      // Long division for the fraction bits of the hit time
      if (struck) begin
         r = num - q*dn;
         f = 0;
         for (i = 0; i < 16; i++) begin
            r = r * 2;
            f = f * 2;
            if (r >= dn) begin
               r = r - dn;
               f = f + 1;
            end
         end
         t = q*65536 + f;
         if (t > longint'(p.tl)) struck = 1'b0;
      end
      if (struck) begin
         for (i = 0; i < 3; i++) begin
            dv[i] = pv[i] + ((vr[i]*t) >>> 16) - cv[i];
            if (dv[i] > (64'sd1 <<< FAR_SH) || dv[i] < -(64'sd1 <<< FAR_SH)) struck = 1'b0;
         end
      end
      if (struck) begin
         u = dv[0]*uv[0] + dv[1]*uv[1] + dv[2]*uv[2];
         v = dv[0]*wv[0] + dv[1]*wv[1] + dv[2]*wv[2];
         hu = longint'(wall_half[31:0]) <<< UNIT_FR;
         hv = longint'(wall_half[63:32]) <<< UNIT_FR;
         if (u < 0) u = -u;
         if (v < 0) v = -v;
         if (u > hu || v > hv) struck = 1'b0;
      end
      // Mirror the relative velocity and advance the position
      if (struck) begin
         s = den >>> UNIT_FR;
         for (i = 0; i < 3; i++) begin
            o.pos[i] = clamp32(pv[i] + ((vv[i]*t) >>> 16));
            o.vel[i] = clamp32(vr[i] - ((2*s*nv[i]) >>> UNIT_FR) + mv[i]);
         end
         o.tl = p.tl - t[TIME_W-1:0];
      end
      return o;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // Drive one particle and hold until the transaction is taken
   task automatic send_particle(input particle_t p, input bit alive, input bit passes);
      bounce_t b;
      req_tdata  <= {1'b0, p};
      req_tuser  <= alive;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (passes) begin
         b.p = p;
         b.flag = 1'b0;
      end else begin
         b.p = bounce_particle(p, alive, b.flag);
      end
      bounce_q.push_back(b);
      sent_count++;
   endtask

   // Random sender gap with valid dropped for a random burst
   task automatic sender_gap();
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (bounce_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [REG_IDX_W-1:0] index, input logic [HALF_W-1:0] data);
      csr_index <= index;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_NORMAL:   wall_normal = data[PVEC_W-1:0];
         REG_AXIS_U:   wall_axis_u = data[PVEC_W-1:0];
         REG_AXIS_V:   wall_axis_v = data[PVEC_W-1:0];
         REG_CENTER:   wall_center = data[PVEC_W-1:0];
         REG_WALL_VEL: wall_vel    = data[PVEC_W-1:0];
         REG_HALF:     wall_half   = data;
         default: ;
      endcase
      csr_count++;
   endtask

   task automatic set_wall(input logic [HALF_W-1:0] n, input logic [HALF_W-1:0] u,
                           input logic [HALF_W-1:0] v, input logic [HALF_W-1:0] c,
                           input logic [HALF_W-1:0] w, input logic [HALF_W-1:0] h);
      drain();
      csr_put(REG_NORMAL, n);
      csr_put(REG_AXIS_U, u);
      csr_put(REG_AXIS_V, v);
      csr_put(REG_CENTER, c);
      csr_put(REG_WALL_VEL, w);
      csr_put(REG_HALF, h);
      csr_valid <= 1'b0;
   endtask

   function automatic stim_row_t row(input longint idx, input longint px, input longint py,
                                     input longint pz, input longint vx, input longint vy,
                                     input longint vz, input longint tl, input bit alive,
                                     input bit passes);
      stim_row_t s;
      s.p.idx = idx[IDX_W-1:0];
      s.p.pos[0] = px[31:0];
      s.p.pos[1] = py[31:0];
      s.p.pos[2] = pz[31:0];
      s.p.vel[0] = vx[31:0];
      s.p.vel[1] = vy[31:0];
      s.p.vel[2] = vz[31:0];
      s.p.tl = tl[TIME_W-1:0];
      s.alive = alive;
      s.passes = passes;
      return s;
   endfunction

   // Particle aimed at the wall from the normal side, random content
   function automatic particle_t aim_particle();
      particle_t p;
      longint a, b, h, spd, ta, tb, span_u, span_v, pi, vi;
      int i;
      span_u = longint'(wall_half[31:0]) * 2 + 16;
      span_v = longint'(wall_half[63:32]) * 2 + 16;
      if (span_u > SPAN_MAX) span_u = SPAN_MAX;
      if (span_v > SPAN_MAX) span_v = SPAN_MAX;
      a = longint'($urandom_range(0, 32'(span_u * 2))) - span_u;
      b = longint'($urandom_range(0, 32'(span_v * 2))) - span_v;
      h = longint'($urandom_range(0, 1 << 19));
      spd = longint'($urandom_range(1 << 12, 1 << 18));
      ta = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
      tb = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
      for (i = 0; i < 3; i++) begin
         pi = vec_comp(wall_center, i, WIDEN_SH) + ((vec_comp(wall_normal, i, 0) * h
              + vec_comp(wall_axis_u, i, 0) * a + vec_comp(wall_axis_v, i, 0) * b) >>> 19);
         vi = vec_comp(wall_vel, i, WIDEN_SH) + ((-vec_comp(wall_normal, i, 0) * spd
              + vec_comp(wall_axis_u, i, 0) * ta + vec_comp(wall_axis_v, i, 0) * tb) >>> 19);
         p.pos[i] = pi[31:0];
         p.vel[i] = vi[31:0];
      end
      p.idx = IDX_W'($urandom);
      p.tl = ($urandom_range(0, 7) == 0) ? {TIME_W{1'b1}} : TIME_W'($urandom_range(0, 1 << 23));
      return p;
   endfunction

   task automatic random_phase(input int count);
      particle_t p;
      logic [8*DATA_W-1:0] raw;
      int k, sel;
      for (k = 0; k < count; k++) begin
         sel = $urandom_range(0, 9);
         if (sel < 7) begin
            p = aim_particle();
         end else begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom};
            p = raw[$bits(particle_t)-1:0];
         end
         sender_gap();
         send_particle(p, sel != 7, 1'b0);
         // Hold off once mid-phase until the pipe is empty
         if (k == count / 2) drain();
      end
   endtask

   // Ready side idles in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transaction against the oldest expectation
   always @(posedge clock) begin
      bounce_t e;
      particle_t got;
      int i;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[TDATA_W-2:0];
         if (bounce_q.size() == 0) begin
            report("unexpected result index", longint'(got.idx), 0);
         end else begin
            e = bounce_q.pop_front();
            if (got.idx != e.p.idx) report("index", longint'(got.idx), longint'(e.p.idx));
            for (i = 0; i < 3; i++) begin
               if (got.pos[i] != e.p.pos[i])
                  report($sformatf("pos[%0d]", i), longint'(got.pos[i]),
                         longint'(e.p.pos[i]));
               if (got.vel[i] != e.p.vel[i])
                  report($sformatf("vel[%0d]", i), longint'(got.vel[i]),
                         longint'(e.p.vel[i]));
            end
            if (got.tl != e.p.tl) report("time_left", longint'(got.tl), longint'(e.p.tl));
            if (rsp_tuser != e.flag) report("hit", longint'(rsp_tuser), longint'(e.flag));
            if (e.flag) hit_count++;
         end
      end
   end

   // Watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", bounce_q.size());
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      stim_row_t rows[$];
      int k;
      logic [HALF_W-1:0] ten_by_ten;
      errors = 0;
      sent_count = 0;
      hit_count = 0;
      csr_count = 0;
      idle_cycles = 0;
      idling_on = 1'b1;
      wall_normal = '0;
      wall_axis_u = '0;
      wall_axis_v = '0;
      wall_center = '0;
      wall_vel = '0;
      wall_half = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_NORMAL;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero registers after reset: no normal speed, so a pass-through
      send_particle(row(1, ONE_Q16, ONE_Q16, ONE_Q16, 0, 0, -ONE_Q16, 2*ONE_Q16, 1, 1).p,
                    1'b1, 1'b1);

      // Floor along z at the origin, 20 by 20 patch
      ten_by_ten = {32'(10*ONE_Q16), 32'(10*ONE_Q16)};
      set_wall(pack_vec(0, 0, ONE_UNIT), pack_vec(ONE_UNIT, 0, 0), pack_vec(0, ONE_UNIT, 0),
               '0, '0, ten_by_ten);

      rows.push_back(row(16'hFFFF, 64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF,
                         -64'sh80000000, 64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF,
                         0, 1)); // dead particle
      rows.push_back(row(2, 0, 0, ONE_Q16, 0, 0, ONE_Q16, 2*ONE_Q16, 1, 1)); // moving away
      rows.push_back(row(3, 0, 0, ONE_Q16, 0, 0, -ONE_Q16, 2*ONE_Q16, 1, 0)); // plain hit
      rows.push_back(row(4, ONE_Q16, -ONE_Q16, 0, ONE_Q16, 0, -ONE_Q16, 5, 1, 0)); // zero time
      rows.push_back(row(5, 0, 0, ONE_Q16, 0, 0, -ONE_Q16, ONE_Q16/2, 1, 1)); // time too short
      rows.push_back(row(6, 20*ONE_Q16, 0, ONE_Q16, 0, 0, -ONE_Q16, 2*ONE_Q16, 1, 0)); // outside
      rows.push_back(row(7, 0, 0, -ONE_Q16, 0, 0, -ONE_Q16, 2*ONE_Q16, 1, 1)); // behind wall
      rows.push_back(row(8, 0, 0, 64'sh40000000, 0, 0, -1, 64'sh7FFFFFFF, 1, 0)); // past range
      rows.push_back(row(9, 0, 0, 1 << 14, 64'sh7FFFFFFF, 0, -1, 64'sh7FFFFFFF, 1, 0)); // far point
      rows.push_back(row(10, 9*ONE_Q16, -9*ONE_Q16, 3*ONE_Q16, ONE_Q16, -ONE_Q16, -ONE_Q16,
                         64'sh7FFFFFFF, 1, 0)); // edge of the patch
      rows.push_back(row(0, 10*ONE_Q16, 10*ONE_Q16, 0, 0, 0, -64'sh80000000, 0, 1, 0)); // corner
      rows.push_back(row(11, -64'sh80000000, 0, 0, -64'sh80000000, 0, -ONE_Q16, 0, 1, 0));
      for (k = 0; k < rows.size(); k++) begin
         sender_gap();
         send_particle(rows[k].p, rows[k].alive, rows[k].passes);
      end

      // Moving wall, half extents at the top of the range: saturating outputs
      set_wall(pack_vec(0, 0, ONE_UNIT), pack_vec(ONE_UNIT, 0, 0), pack_vec(0, ONE_UNIT, 0),
               pack_vec(2048, -2048, 1024), pack_vec(0, 0, -64'sd1048576), '1);
      send_particle(row(12, 64'sh7FFF0000, 0, ONE_Q16, 64'sh7FFFFFFF, 0, -ONE_Q16,
                        4*ONE_Q16, 1, 0).p, 1'b1, 1'b0);
      send_particle(row(13, 0, 0, ONE_Q16, 0, 64'sh7FFFFFFF, 64'sh7FFFFFFF, 64'sh7FFFFFFF,
                        1, 0).p, 1'b1, 1'b0);
      random_phase(200);

      // Tilted wall with 45 degree axes, spare register indexes are ignored
      drain();
      csr_put(REG_SPARE_LO, '1);
      csr_put(REG_SPARE_HI, '1);
      set_wall(pack_vec(0, DIAG_UNIT, DIAG_UNIT), pack_vec(ONE_UNIT, 0, 0),
               pack_vec(0, -DIAG_UNIT, DIAG_UNIT), pack_vec(-4096, 300, 77),
               pack_vec(100, -50, 25), {32'(3*ONE_Q16), 32'(5*ONE_Q16)});
      random_phase(220);

      // Wall facing negative x, zero-size patch
      set_wall(pack_vec(-ONE_UNIT, 0, 0), pack_vec(0, ONE_UNIT, 0), pack_vec(0, 0, ONE_UNIT),
               pack_vec(64'sd1048575, -64'sd1048576, 0), pack_vec(-64'sd1048576, 0, 5), '0);
      random_phase(200);

      // Every register bit set
      set_wall('1, '1, '1, '1, '1, '1);
      random_phase(150);

      // Random non-unit vectors and random extents
      set_wall({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      random_phase(120);

      // Floor again, then a final stretch with both sides streaming flat out
      set_wall(pack_vec(0, 0, ONE_UNIT), pack_vec(ONE_UNIT, 0, 0), pack_vec(0, ONE_UNIT, 0),
               pack_vec(512, 512, -512), pack_vec(30, 0, 0), ten_by_ten);
      random_phase(60);
      idling_on = 1'b0;
      random_phase(140);

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d particles with %0d wall hits over %0d register writes",
               sent_count, hit_count, csr_count);
      $display("wall setups: floor, moving, tilted, reversed, all-ones, random");
      if (errors == 0 && bounce_q.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
